@@ hw/rtl/gspa_pkg.sv @@
// gspa_pkg: shared types, codes and constants of the growable slot pool allocator
// used by gspa_front, gspa_back and growable_slot_pool_allocator; no dependencies

package gspa_pkg;

  // sizing of the pool
  localparam int MAX_PAGES          = 16;
  localparam int MAX_SLOTS_PER_PAGE = 64;
  localparam int HANDLE_SPACE       = 1024;
  localparam int HANDLE_W           = 10;
  localparam int COUNT_W            = 11;
  localparam int PAGE_W             = 5;
  localparam int SPP_W              = 7;
  localparam int BYTES_W            = 13;
  localparam int CFG_IDX_W          = 2;
  localparam int QUEUE_DEPTH        = 2;
  localparam int QPTR_W             = 1;

  // reset values of the configuration registers and the in-use count limit
  localparam logic [SPP_W-1:0]   SPP_RESET       = SPP_W'(16);
  localparam logic [BYTES_W-1:0] SLOT_SIZE_RESET = BYTES_W'(64);
  localparam logic [COUNT_W-1:0] IN_USE_MAX      = COUNT_W'(2047);

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PAGE_SLOTS = 2'd0,
    CFG_SLOT_SIZE  = 2'd1
  } cfg_index_t;

  // command opcodes
  typedef enum logic [1:0] {
    OPC_ALLOC = 2'd0,
    OPC_FREE  = 2'd1,
    OPC_QUERY = 2'd2
  } opcode_t;

  // result status codes
  typedef enum logic [1:0] {
    STS_OK        = 2'd0,
    STS_EXHAUSTED = 2'd1,
    STS_IGNORED   = 2'd2
  } status_t;

  // operation class decided by the front end
  typedef enum logic [1:0] {
    KIND_ALLOC,
    KIND_FREE,
    KIND_QUERY,
    KIND_NOP
  } kind_t;

  // back end sequencer states
  typedef enum logic {
    BK_IDLE,
    BK_POP
  } back_state_t;

  // command payload
  typedef struct packed {
    logic [1:0]          opcode;
    logic                has_handle;
    logic [HANDLE_W-1:0] slot_handle;
  } cmd_t;

  // result payload
  typedef struct packed {
    logic [HANDLE_W-1:0] granted_slot;
    logic [1:0]          status;
    logic                is_owned;
    logic [BYTES_W-1:0]  size_of_slot;
    logic [COUNT_W-1:0]  in_use_count;
    logic [COUNT_W-1:0]  free_count;
    logic [PAGE_W-1:0]   page_total;
  } rsp_t;

  // classified entry of the queue between front and back
  typedef struct packed {
    kind_t               kind;
    logic                has_handle;
    logic [HANDLE_W-1:0] slot_handle;
  } queue_item_t;

  // configuration seen by the back end
  typedef struct packed {
    logic [SPP_W-1:0]   page_slots;
    logic [BYTES_W-1:0] slot_size;
  } cfg_t;

endpackage

@@ hw/rtl/gspa_front.sv @@
// gspa_front: takes commands, classifies them by opcode and queues them
// depends on gspa_pkg

module gspa_front (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  gspa_pkg::cmd_t        cmd,
  output logic                  q_valid,
  output gspa_pkg::queue_item_t q_item,
  input  logic                  q_pop
);

  gspa_pkg::queue_item_t entry [gspa_pkg::QUEUE_DEPTH];
  logic [gspa_pkg::QPTR_W-1:0] wr_ptr;
  logic [gspa_pkg::QPTR_W-1:0] rd_ptr;
  logic [gspa_pkg::QPTR_W:0]   fill;
  logic                        push;
  logic                        pop;
  gspa_pkg::queue_item_t       classified;

  // classify the incoming command
  always_comb begin
    classified.has_handle  = cmd.has_handle;
    classified.slot_handle = cmd.slot_handle;
    case (cmd.opcode)
      gspa_pkg::OPC_ALLOC: classified.kind = gspa_pkg::KIND_ALLOC;
      gspa_pkg::OPC_FREE:  classified.kind = gspa_pkg::KIND_FREE;
      gspa_pkg::OPC_QUERY: classified.kind = gspa_pkg::KIND_QUERY;
      default:             classified.kind = gspa_pkg::KIND_NOP;
    endcase
  end

  // queue handshake
  assign busy    = (fill == (gspa_pkg::QPTR_W+1)'(gspa_pkg::QUEUE_DEPTH));
  assign push    = start && !busy;
  assign q_valid = (fill != '0);
  assign pop     = q_pop && q_valid;
  assign q_item  = entry[rd_ptr];

  // queue pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      case ({push, pop})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (push) entry[wr_ptr] <= classified;
  end

endmodule

@@ hw/rtl/gspa_back.sv @@
// gspa_back: carries out queued allocate, free and query operations on the pool
// holds the link store memory; depends on gspa_pkg

module gspa_back (
  input  logic                  clk,
  input  logic                  rst,
  input  gspa_pkg::cfg_t        cfg,
  input  logic                  q_valid,
  input  gspa_pkg::queue_item_t q_item,
  output logic                  q_pop,
  output logic                  done,
  output gspa_pkg::rsp_t        rsp
);

  localparam int HW = gspa_pkg::HANDLE_W;
  localparam int CW = gspa_pkg::COUNT_W;

  gspa_pkg::back_state_t state, state_next;

  // link store
  logic [HW-1:0] link_mem [gspa_pkg::HANDLE_SPACE];
  logic          mem_we;
  logic [HW-1:0] mem_waddr;
  logic [HW-1:0] mem_wdata;
  logic          mem_re;
  logic [HW-1:0] mem_rdata;

  // pool state
  logic [HW-1:0]              list_head, list_head_next;
  logic                       list_nonempty, list_nonempty_next;
  logic [CW-1:0]              fresh_slot, fresh_slot_next;
  logic [CW-1:0]              provisioned_slots, provisioned_slots_next;
  logic [gspa_pkg::PAGE_W-1:0] pages_used, pages_used_next;
  logic [CW-1:0]              slots_in_use, slots_in_use_next;

  logic           rsp_load;
  gspa_pkg::rsp_t rsp_next;

  logic [gspa_pkg::SPP_W-1:0] span;
  logic [CW:0]                grown;
  logic                       owned;
  logic                       fresh_ready;

  // clamped page size
  always_comb begin
    if (cfg.page_slots == '0) begin
      span = gspa_pkg::SPP_W'(1);
    end else if (cfg.page_slots > gspa_pkg::SPP_W'(gspa_pkg::MAX_SLOTS_PER_PAGE)) begin
      span = gspa_pkg::SPP_W'(gspa_pkg::MAX_SLOTS_PER_PAGE);
    end else begin
      span = cfg.page_slots;
    end
  end

  // provisioned limit after opening a page, cut at the handle space
  always_comb begin
    grown = {1'b0, provisioned_slots} + (CW+1)'(span);
    if (grown > (CW+1)'(gspa_pkg::HANDLE_SPACE)) grown = (CW+1)'(gspa_pkg::HANDLE_SPACE);
  end

  assign owned = q_item.has_handle && ({1'b0, q_item.slot_handle} < provisioned_slots);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      gspa_pkg::BK_IDLE: begin
        if (q_valid && q_item.kind == gspa_pkg::KIND_ALLOC && list_nonempty) begin
          state_next = gspa_pkg::BK_POP;
        end
      end
      gspa_pkg::BK_POP: state_next = gspa_pkg::BK_IDLE;
      default:          state_next = gspa_pkg::BK_IDLE;
    endcase
  end

  // operation datapath and result
  always_comb begin
    q_pop                  = 1'b0;
    mem_we                 = 1'b0;
    mem_waddr              = q_item.slot_handle;
    mem_wdata              = list_nonempty ? list_head : q_item.slot_handle;
    mem_re                 = 1'b0;
    list_head_next         = list_head;
    list_nonempty_next     = list_nonempty;
    fresh_slot_next        = fresh_slot;
    provisioned_slots_next = provisioned_slots;
    pages_used_next        = pages_used;
    slots_in_use_next      = slots_in_use;
    rsp_load               = 1'b0;
    rsp_next               = '0;
    rsp_next.status        = gspa_pkg::STS_OK;
    fresh_ready            = fresh_slot < provisioned_slots;
    case (state)
      gspa_pkg::BK_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          case (q_item.kind)
            gspa_pkg::KIND_ALLOC: begin
              if (list_nonempty) begin
                // fetch the link of the head, finish next cycle
                mem_re = 1'b1;
              end else begin
                rsp_load = 1'b1;
                if (!fresh_ready &&
                    pages_used < gspa_pkg::PAGE_W'(gspa_pkg::MAX_PAGES) &&
                    provisioned_slots < CW'(gspa_pkg::HANDLE_SPACE)) begin
                  provisioned_slots_next = grown[CW-1:0];
                  pages_used_next        = pages_used + 1'b1;
                  fresh_ready            = 1'b1;
                end
                if (fresh_ready) begin
                  rsp_next.granted_slot = fresh_slot[HW-1:0];
                  fresh_slot_next       = fresh_slot + 1'b1;
                  if (slots_in_use < gspa_pkg::IN_USE_MAX) begin
                    slots_in_use_next = slots_in_use + 1'b1;
                  end
                end else begin
                  rsp_next.status = gspa_pkg::STS_EXHAUSTED;
                end
              end
            end
            gspa_pkg::KIND_FREE: begin
              rsp_load = 1'b1;
              if (owned) begin
                mem_we             = 1'b1;
                list_head_next     = q_item.slot_handle;
                list_nonempty_next = 1'b1;
                if (slots_in_use != '0) slots_in_use_next = slots_in_use - 1'b1;
              end else begin
                rsp_next.status = gspa_pkg::STS_IGNORED;
              end
            end
            gspa_pkg::KIND_QUERY: begin
              rsp_load = 1'b1;
              if (owned) begin
                rsp_next.is_owned     = 1'b1;
                rsp_next.size_of_slot = cfg.slot_size;
              end
            end
            default: rsp_load = 1'b1;
          endcase
        end
      end
      gspa_pkg::BK_POP: begin
        // pop with the fetched link; a self link ends the list
        rsp_load              = 1'b1;
        rsp_next.granted_slot = list_head;
        if (mem_rdata == list_head) list_nonempty_next = 1'b0;
        else                        list_head_next     = mem_rdata;
        if (slots_in_use < gspa_pkg::IN_USE_MAX) slots_in_use_next = slots_in_use + 1'b1;
      end
      default: ;
    endcase
    // counts after the operation
    rsp_next.in_use_count = slots_in_use_next;
    rsp_next.free_count   = (slots_in_use_next >= provisioned_slots_next) ? '0
                            : provisioned_slots_next - slots_in_use_next;
    rsp_next.page_total   = pages_used_next;
  end

  // control and pool registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= gspa_pkg::BK_IDLE;
      list_head         <= '0;
      list_nonempty     <= 1'b0;
      fresh_slot        <= '0;
      provisioned_slots <= '0;
      pages_used        <= '0;
      slots_in_use      <= '0;
      done              <= 1'b0;
    end else begin
      state             <= state_next;
      list_head         <= list_head_next;
      list_nonempty     <= list_nonempty_next;
      fresh_slot        <= fresh_slot_next;
      provisioned_slots <= provisioned_slots_next;
      pages_used        <= pages_used_next;
      slots_in_use      <= slots_in_use_next;
      done              <= rsp_load;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rsp_load) rsp <= rsp_next;
  end

  // link store access
  always_ff @(posedge clk) begin
    if (mem_we) link_mem[mem_waddr] <= mem_wdata;
    if (mem_re) mem_rdata <= link_mem[list_head];
  end

endmodule

@@ hw/rtl/growable_slot_pool_allocator.sv @@
// growable_slot_pool_allocator: top level with configuration registers
// instantiates gspa_front and gspa_back; depends on gspa_pkg

// A command is taken when start is high and busy is low; busy rises only while the
// two-entry command queue is full. Each command yields exactly one result, shown on
// rsp for one cycle with done high; the receiver cannot stall it. With the back end
// idle, a free, a query or an allocate with an empty free list passes through the
// command queue and is then finished in the back end, which registers done; an allocate
// that pops the free list also waits for the registered read of the 1024-entry link
// store, and the back end takes no new command from the queue while it does.
// The link store is not cleared at reset and needs no clearing pass: it is only read
// at entries written by an earlier free. Configuration writes are always accepted
// (cfg_ready high) and belong between commands only; indexes past the slot size
// register are dropped, and a new page size affects only pages opened afterwards.

module growable_slot_pool_allocator (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  output logic                                 busy,
  input  gspa_pkg::cmd_t                       cmd,
  output logic                                 done,
  output gspa_pkg::rsp_t                       rsp,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [gspa_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [gspa_pkg::BYTES_W-1:0]         cfg_data
);

  gspa_pkg::cfg_t        cfg;
  logic                  q_valid;
  logic                  q_pop;
  gspa_pkg::queue_item_t q_item;

  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.page_slots <= gspa_pkg::SPP_RESET;
      cfg.slot_size  <= gspa_pkg::SLOT_SIZE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        gspa_pkg::CFG_PAGE_SLOTS: cfg.page_slots <= cfg_data[gspa_pkg::SPP_W-1:0];
        gspa_pkg::CFG_SLOT_SIZE:  cfg.slot_size  <= cfg_data;
        default: ;
      endcase
    end
  end

  // command intake and queue
  gspa_front u_front (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .cmd     (cmd),
    .q_valid (q_valid),
    .q_item  (q_item),
    .q_pop   (q_pop)
  );

  // pool execution
  gspa_back u_back (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .q_valid (q_valid),
    .q_item  (q_item),
    .q_pop   (q_pop),
    .done    (done),
    .rsp     (rsp)
  );

endmodule
